// ===== src/pmrp_pkg.sv =====
// pmrp_pkg: shared types, widths and constants of the point-in-mesh ray parity block
// no dependencies; used by the interfaces and every module

package pmrp_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;            // vertex and point differences
	localparam int DET_W = 2 * DIFF_W + 1;          // det, u and v numerators, q
	localparam int QH_W = DET_W - 32;               // high part of q for the split multiply
	localparam int PROD_W = DIFF_W + QH_W;          // shared multiplier result
	localparam int TN_W = DIFF_W + DET_W + 4;       // t numerator
	localparam int TOL_DEN_W = 18;
	localparam int M_W = TN_W + TOL_DEN_W;          // t numerator times tolerance denominator
	localparam int CNT_W = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int DEF_MAX_TRIANGLES = 65535;
	localparam int DEF_FRAC_BITS = 16;
	localparam longint unsigned TOL_DEN = 100000;

	// 100000 = 2^16 + 2^15 + 2^10 + 2^9 + 2^7 + 2^5
	localparam int N_TOL_TERMS = 6;
	localparam int TERM_W = $clog2(N_TOL_TERMS);
	localparam int TOL_SHIFT [N_TOL_TERMS] = '{16, 15, 10, 9, 7, 5};

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
		logic last_triangle;
	} tri_t;

	typedef struct packed {
		logic inside_res;
		logic [CNT_W-1:0] hit_count;
	} res_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] e1x;
		logic signed [DIFF_W-1:0] e1y;
		logic signed [DIFF_W-1:0] e1z;
		logic signed [DIFF_W-1:0] e2x;
		logic signed [DIFF_W-1:0] e2y;
		logic signed [DIFF_W-1:0] e2z;
		logic signed [DIFF_W-1:0] sx;
		logic signed [DIFF_W-1:0] sy;
		logic signed [DIFF_W-1:0] sz;
		logic last;
	} job_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_DRAIN,
		B_FOLD,
		B_SCALE,
		B_DONE
	} back_state_t;

endpackage

// ===== src/pmrp_if.sv =====
// pmrp_if: valid/ready channel interfaces for triangles, results and configuration
// depends on pmrp_pkg

interface pmrp_tri_if import pmrp_pkg::*;;
	logic valid;
	logic ready;
	tri_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pmrp_res_if import pmrp_pkg::*;;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pmrp_cfg_if import pmrp_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COORD_W-1:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== src/pmrp_queue.sv =====
// pmrp_queue: short register queue of classified triangle jobs between front and back
// depends on pmrp_pkg

module pmrp_queue import pmrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  hs_t  push,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop,
	output job_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_QW-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (fill_q != CNT_QW'(DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/pmrp_front.sv =====
// pmrp_front: query point registers, triangle intake and edge/offset vectors
// depends on pmrp_pkg and pmrp_if

module pmrp_front import pmrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pmrp_cfg_if.sink cfg,
	pmrp_tri_if.sink tri_in,
	output hs_t  push,
	output job_t push_data
);

	logic signed [COORD_W-1:0] point_x_q;
	logic signed [COORD_W-1:0] point_y_q;
	logic signed [COORD_W-1:0] point_z_q;

	assign cfg.ready = 1'b1;

	// writes to an unknown index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			point_z_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POINT_X: point_x_q <= $signed(cfg.wdata);
				REG_POINT_Y: point_y_q <= $signed(cfg.wdata);
				REG_POINT_Z: point_z_q <= $signed(cfg.wdata);
				default: ;
			endcase
		end
	end

	assign push.valid = tri_in.valid;
	assign push.ready = 1'b0;

	// edges from vertex a, and the point's offset from a
	always_comb begin
		push_data.e1x = DIFF_W'(tri_in.data.b_x) - DIFF_W'(tri_in.data.a_x);
		push_data.e1y = DIFF_W'(tri_in.data.b_y) - DIFF_W'(tri_in.data.a_y);
		push_data.e1z = DIFF_W'(tri_in.data.b_z) - DIFF_W'(tri_in.data.a_z);
		push_data.e2x = DIFF_W'(tri_in.data.c_x) - DIFF_W'(tri_in.data.a_x);
		push_data.e2y = DIFF_W'(tri_in.data.c_y) - DIFF_W'(tri_in.data.a_y);
		push_data.e2z = DIFF_W'(tri_in.data.c_z) - DIFF_W'(tri_in.data.a_z);
		push_data.sx = DIFF_W'(point_x_q) - DIFF_W'(tri_in.data.a_x);
		push_data.sy = DIFF_W'(point_y_q) - DIFF_W'(tri_in.data.a_y);
		push_data.sz = DIFF_W'(point_z_q) - DIFF_W'(tri_in.data.a_z);
		push_data.last = tri_in.data.last_triangle;
	end

endmodule

// ===== src/pmrp_back.sv =====
// pmrp_back: crossing test on one shared multiplier, tolerance scaling, counter, result register
// depends on pmrp_pkg and pmrp_if

module pmrp_back import pmrp_pkg::*; #(
	parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	pmrp_res_if.source res
);

	localparam logic [CNT_W-1:0] CNT_MAX =
		(MAX_TRIANGLES < 65535) ? CNT_W'(MAX_TRIANGLES) : {CNT_W{1'b1}};
	// |det| * 100000 < 2^(2F)  <=>  |det| < ceil(2^(2F) / 100000)
	localparam logic [DET_W-1:0] TOL_T =
		DET_W'(((64'd1 << (2 * FRAC_BITS)) + TOL_DEN - 64'd1) / TOL_DEN);

	// multiply schedule
	localparam logic [3:0] ST_DET_A = 4'd0;
	localparam logic [3:0] ST_DET_B = 4'd1;
	localparam logic [3:0] ST_U_A = 4'd2;
	localparam logic [3:0] ST_U_B = 4'd3;
	localparam logic [3:0] ST_QX_A = 4'd4;
	localparam logic [3:0] ST_QX_B = 4'd5;
	localparam logic [3:0] ST_QY_A = 4'd6;
	localparam logic [3:0] ST_QY_B = 4'd7;
	localparam logic [3:0] ST_QZ_A = 4'd8;
	localparam logic [3:0] ST_QZ_B = 4'd9;
	localparam logic [3:0] ST_TX_LO = 4'd10;
	localparam logic [3:0] ST_TX_HI = 4'd11;
	localparam logic [3:0] ST_TY_LO = 4'd12;
	localparam logic [3:0] ST_TY_HI = 4'd13;
	localparam logic [3:0] ST_TZ_LO = 4'd14;
	localparam logic [3:0] ST_TZ_HI = 4'd15;

	back_state_t state_q, state_d;
	logic [3:0] step_q;
	logic [3:0] acc_tag_q;
	logic acc_en_q;
	logic [TERM_W-1:0] term_q;
	logic [CNT_W-1:0] cnt_q;
	logic res_vld_q;
	res_t res_q;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [DET_W-1:0] det_q, un_q, vn_q, qy_q, qz_q;
	logic signed [TN_W-1:0] tn_q;
	logic signed [M_W-1:0] m_q;

	logic signed [DIFF_W-1:0] op_a;
	logic signed [QH_W-1:0] op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [DET_W:0] sum_uv;
	logic out_free, hit, finish;
	logic [CNT_W-1:0] cnt_next;

	always_comb begin
		op_a = job.e1z;
		op_b = QH_W'(job.e2y);
		case (step_q)
			ST_DET_A: begin op_a = job.e1z; op_b = QH_W'(job.e2y); end
			ST_DET_B: begin op_a = job.e1y; op_b = QH_W'(job.e2z); end
			ST_U_A:   begin op_a = job.sz;  op_b = QH_W'(job.e2y); end
			ST_U_B:   begin op_a = job.sy;  op_b = QH_W'(job.e2z); end
			ST_QX_A:  begin op_a = job.sy;  op_b = QH_W'(job.e1z); end
			ST_QX_B:  begin op_a = job.sz;  op_b = QH_W'(job.e1y); end
			ST_QY_A:  begin op_a = job.sz;  op_b = QH_W'(job.e1x); end
			ST_QY_B:  begin op_a = job.sx;  op_b = QH_W'(job.e1z); end
			ST_QZ_A:  begin op_a = job.sx;  op_b = QH_W'(job.e1y); end
			ST_QZ_B:  begin op_a = job.sy;  op_b = QH_W'(job.e1x); end
			ST_TX_LO: begin op_a = job.e2x; op_b = $signed(QH_W'(vn_q[31:0])); end
			ST_TX_HI: begin op_a = job.e2x; op_b = $signed(vn_q[DET_W-1:32]); end
			ST_TY_LO: begin op_a = job.e2y; op_b = $signed(QH_W'(qy_q[31:0])); end
			ST_TY_HI: begin op_a = job.e2y; op_b = $signed(qy_q[DET_W-1:32]); end
			ST_TZ_LO: begin op_a = job.e2z; op_b = $signed(QH_W'(qz_q[31:0])); end
			ST_TZ_HI: begin op_a = job.e2z; op_b = $signed(qz_q[DET_W-1:32]); end
			default: ;
		endcase
		prod = op_a * op_b;
	end

	// decision, with det already folded to be non-negative
	always_comb begin
		sum_uv = (DET_W + 1)'(un_q) + (DET_W + 1)'(vn_q);
		hit = ($unsigned(det_q) >= TOL_T)
			&& (un_q >= 0) && (det_q >= un_q)
			&& (vn_q >= 0) && ((DET_W + 1)'(det_q) >= sum_uv)
			&& ((M_W'(det_q) <<< FRAC_BITS) < m_q);
		cnt_next = (hit && (cnt_q < CNT_MAX)) ? cnt_q + 1'b1 : cnt_q;
	end

	assign out_free = !res_vld_q || res.ready;
	assign finish = (state_q == B_DONE) && (!job.last || out_free);
	assign res.valid = res_vld_q;
	assign res.data = res_q;

	always_comb begin
		state_d = state_q;
		job_pop = 1'b0;
		case (state_q)
			B_IDLE:  if (job_valid) state_d = B_MUL;
			B_MUL:   if (step_q == ST_TZ_HI) state_d = B_DRAIN;
			B_DRAIN: state_d = B_FOLD;
			B_FOLD:  state_d = B_SCALE;
			B_SCALE: if (term_q == TERM_W'(N_TOL_TERMS - 1)) state_d = B_DONE;
			B_DONE: begin
				if (finish) begin
					state_d = B_IDLE;
					job_pop = 1'b1;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
			acc_en_q <= 1'b0;
			term_q <= '0;
			cnt_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= (state_q == B_MUL) ? step_q + 1'b1 : '0;
			acc_en_q <= (state_q == B_MUL);
			term_q <= (state_q == B_SCALE) ? term_q + 1'b1 : '0;
			// a new result may load in the same cycle the old one is taken
			if (finish && job.last) begin
				res_vld_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				res_vld_q <= 1'b0;
			end
			if (finish) begin
				cnt_q <= job.last ? '0 : cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
		acc_tag_q <= step_q;
		if (finish && job.last) begin
			res_q.inside_res <= cnt_next[0];
			res_q.hit_count <= cnt_next;
		end
		if (acc_en_q) begin
			case (acc_tag_q)
				ST_DET_A: det_q <= DET_W'(prod_q);
				ST_DET_B: det_q <= det_q - DET_W'(prod_q);
				ST_U_A:   un_q <= DET_W'(prod_q);
				ST_U_B:   un_q <= un_q - DET_W'(prod_q);
				ST_QX_A:  vn_q <= DET_W'(prod_q);
				ST_QX_B:  vn_q <= vn_q - DET_W'(prod_q);
				ST_QY_A:  qy_q <= DET_W'(prod_q);
				ST_QY_B:  qy_q <= qy_q - DET_W'(prod_q);
				ST_QZ_A:  qz_q <= DET_W'(prod_q);
				ST_QZ_B:  qz_q <= qz_q - DET_W'(prod_q);
				ST_TX_LO: tn_q <= TN_W'(prod_q);
				ST_TY_LO, ST_TZ_LO: tn_q <= tn_q + TN_W'(prod_q);
				ST_TX_HI, ST_TY_HI, ST_TZ_HI: tn_q <= tn_q + (TN_W'(prod_q) <<< 32);
				default: ;
			endcase
		end
		if (state_q == B_FOLD) begin
			m_q <= '0;
			if (det_q < 0) begin
				det_q <= -det_q;
				un_q <= -un_q;
				vn_q <= -vn_q;
				tn_q <= -tn_q;
			end
		end
		if (state_q == B_SCALE) begin
			m_q <= m_q + (M_W'(tn_q) <<< TOL_SHIFT[term_q]);
		end
	end

endmodule

// ===== src/point_in_mesh_ray_parity_top.sv =====
// point_in_mesh_ray_parity_top: +X ray crossing parity of a query point against a triangle mesh
// depends on pmrp_pkg, pmrp_if, pmrp_front, pmrp_queue, pmrp_back
// back end, one triangle at a time: an idle step, 16 products on the shared multiplier,
//   drain, fold, 6 tolerance scaling adds and the decision step; the queue holds 2 requests
// reset: arst_n clears the point registers to 0, the crossing count, queue and result valid

module point_in_mesh_ray_parity_top import pmrp_pkg::*; #(
	parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	pmrp_cfg_if.sink cfg,
	pmrp_tri_if.sink tri_in,
	pmrp_res_if.source res
);

	// front to queue
	hs_t  push;
	logic push_ready;
	job_t push_data;

	// queue to back
	logic job_valid;
	logic job_pop;
	job_t job;

	// front: point registers, takes a triangle request whenever the queue has room,
	// forms edges e1 = b - a, e2 = c - a and offset s = point - a
	pmrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.tri_in    (tri_in),
		.push      (push),
		.push_data (push_data)
	);

	assign tri_in.ready = push_ready;

	// short queue so intake keeps going while the back end iterates or the result stalls
	pmrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (job_valid),
		.pop        (job_pop),
		.pop_data   (job)
	);

	// back: determinant, barycentric and t numerators through one multiplier,
	// exact tolerance compares, saturating count, result register on the last triangle
	pmrp_back #(
		.MAX_TRIANGLES (MAX_TRIANGLES),
		.FRAC_BITS     (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.res       (res)
	);

endmodule
